// File: rtl/glzw_pkg.sv
// Package for the GIF LZW pixel decoder: word types, status codes, FSM states.
// No dependencies.
package glzw_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pixel_index;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        is_transparent;
        logic        last_pixel;
    } t_out_word;

    localparam logic [2:0] STAT_TAKEN   = 3'd0;
    localparam logic [2:0] STAT_REFUSED = 3'd1;
    localparam logic [2:0] STAT_PIXEL   = 3'd2;
    localparam logic [2:0] STAT_NEED    = 3'd3;
    localparam logic [2:0] STAT_DONE    = 3'd4;

    localparam logic ACT_BYTE = 1'b0;

    localparam logic [2:0] REG_MIN_CODE  = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_TRANS_EN  = 3'd3;
    localparam logic [2:0] REG_TRANS_IDX = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DECODE,
        S_WALK,
        S_WAIT
    } t_state;

endpackage

// File: rtl/glzw_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/gif_lzw_pixel_decoder.sv
// GIF LZW pixel decoder top level.
// Depends on glzw_pkg and glzw_ram.
//
// Stream bytes (length bytes included) are taken one per word. A pixel request that
// finds symbols on the expansion stack answers from one stack RAM read. A request
// whose code follows a clear code answers from S_DECODE, which first consumes any
// clear codes met. A request that decodes any other code walks its chain in S_WALK,
// with one prefix/suffix RAM read in S_WAIT per table entry walked and one zero
// symbol pushed per corrupt link; an undefined code adds no state. The walked
// symbols are then handed out one per request from the stack. No clearing pass
// after reset: table entries at or above the next free code are never read.
module gif_lzw_pixel_decoder #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  glzw_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output glzw_pkg::t_out_word  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import glzw_pkg::*;

    localparam int CB  = MAX_CODE_BITS;
    localparam int NB  = MAX_CODE_BITS + 1;
    localparam int TS  = 1 << MAX_CODE_BITS;
    localparam int SS  = TS + 1;
    localparam int SAW = $clog2(SS);

    function automatic logic [3:0] f_eff(input logic [3:0] m);
        if (m < 4'd2) return 4'd2;
        if (m > 4'd8) return 4'd8;
        return m;
    endfunction

    t_state r_state, n_state;
    logic [3:0]  r_min, n_min;
    logic [15:0] r_w, n_w, r_h, n_h;
    logic        r_ten, n_ten;
    logic [7:0]  r_tidx, n_tidx;
    logic [NB-1:0] r_depth, n_depth;
    logic [23:0] r_buf, n_buf;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_left, n_left;
    logic        r_ended, n_ended;
    logic [4:0]  r_cw, n_cw;
    logic [NB-1:0] r_nfc, n_nfc, r_wl, n_wl;
    logic [CB-1:0] r_prev, n_prev, r_code, n_code, r_incode, n_incode;
    logic [7:0]  r_fs, n_fs;
    logic        r_ac, n_ac;
    logic [15:0] r_col, n_col, r_row, n_row;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic          stk_we;
    logic [7:0]    stk_wdata, stk_rdata;
    logic          tab_we;
    logic [CB-1:0] pre_rdata;
    logic [7:0]    suf_rdata;

    logic          in_fire, cfg_fire, done;
    logic [3:0]    eff;
    logic [NB-1:0] clr;
    logic [CB-1:0] code;
    logic          do_emit, do_stat;
    logic [7:0]    pix;
    logic [2:0]    stat;
    logic [3:0]    ceff;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid;
    assign done        = r_row >= r_h;
    assign eff         = f_eff(r_min);
    assign clr         = NB'(1) << eff;
    assign code        = CB'(r_buf & ((24'd1 << r_cw) - 24'd1));

    glzw_ram #(.WIDTH(CB), .DEPTH(TS)) u_prefix (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(r_nfc[CB-1:0]), .i_wdata(r_prev),
        .i_raddr(r_code), .o_rdata(pre_rdata)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(TS)) u_suffix (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(r_nfc[CB-1:0]), .i_wdata(n_fs),
        .i_raddr(r_code), .o_rdata(suf_rdata)
    );
    glzw_ram #(.WIDTH(8), .DEPTH(SS)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(r_depth[SAW-1:0]), .i_wdata(stk_wdata),
        .i_raddr(SAW'(r_depth - NB'(1))), .o_rdata(stk_rdata)
    );

    always_comb begin
        n_state = r_state;  n_min = r_min;  n_w = r_w;  n_h = r_h;
        n_ten = r_ten;  n_tidx = r_tidx;  n_depth = r_depth;  n_buf = r_buf;
        n_cnt = r_cnt;  n_left = r_left;  n_ended = r_ended;  n_cw = r_cw;
        n_nfc = r_nfc;  n_wl = r_wl;  n_prev = r_prev;  n_code = r_code;
        n_incode = r_incode;  n_fs = r_fs;  n_ac = r_ac;  n_col = r_col;  n_row = r_row;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out = r_out;
        stk_we = 1'b0;  stk_wdata = 8'd0;  tab_we = 1'b0;
        do_emit = 1'b0;  do_stat = 1'b0;  pix = 8'd0;  stat = STAT_TAKEN;
        ceff = 4'd0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.action == ACT_BYTE) begin
                        do_stat = 1'b1;
                        if (!(r_ended || done)) begin
                            if (r_left == 8'd0) begin
                                if (i_in_data.data_byte == 8'd0) n_ended = 1'b1;
                                else n_left = i_in_data.data_byte;
                            end else if (r_cnt > 5'd16) begin
                                stat = STAT_REFUSED;
                            end else begin
                                n_buf  = r_buf | (24'(i_in_data.data_byte) << r_cnt);
                                n_cnt  = r_cnt + 5'd8;
                                n_left = r_left - 8'd1;
                            end
                        end
                    end else if (done) begin
                        do_stat = 1'b1;
                        stat = STAT_DONE;
                    end else if (r_depth != '0) begin
                        n_depth = r_depth - NB'(1);
                        n_state = S_POP;
                    end else begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_POP: begin
                do_emit = 1'b1;
                pix = stk_rdata;
                n_state = S_IDLE;
            end
            S_DECODE: begin
                if (r_cnt < r_cw) begin
                    do_stat = 1'b1;
                    stat = r_ended ? STAT_DONE : STAT_NEED;
                    n_state = S_IDLE;
                end else begin
                    n_buf = r_buf >> r_cw;
                    n_cnt = r_cnt - r_cw;
                    if (NB'(code) == clr) begin
                        n_cw  = 5'(eff) + 5'd1;
                        n_nfc = clr + NB'(2);
                        n_wl  = clr << 1;
                        n_ac  = 1'b1;
                    end else if (NB'(code) == clr + NB'(1)) begin
                        n_ended = 1'b1;
                        n_buf = '0;
                        n_cnt = '0;
                        do_stat = 1'b1;
                        stat = STAT_DONE;
                        n_state = S_IDLE;
                    end else if (r_ac) begin
                        n_ac = 1'b0;
                        n_fs = code[7:0];
                        n_prev = code;
                        do_emit = 1'b1;
                        pix = code[7:0];
                        n_state = S_IDLE;
                    end else begin
                        n_incode = code;
                        n_state = S_WALK;
                        if (NB'(code) >= r_nfc) begin
                            // code not yet in the table: previous string + its first symbol
                            stk_we = 1'b1;
                            stk_wdata = r_fs;
                            n_depth = r_depth + NB'(1);
                            n_code = r_prev;
                        end else begin
                            n_code = code;
                        end
                    end
                end
            end
            S_WALK: begin
                if (NB'(r_code) >= clr && r_depth < NB'(TS)) begin
                    if (NB'(r_code) < clr + NB'(2) || NB'(r_code) >= r_nfc) begin
                        stk_we = 1'b1;
                        stk_wdata = 8'd0;
                        n_depth = r_depth + NB'(1);
                        n_code = '0;
                    end else begin
                        n_state = S_WAIT;
                    end
                end else begin
                    // chain root reached; it would be pushed and popped at once, so emit it directly
                    n_fs = (NB'(r_code) < clr) ? r_code[7:0] : 8'd0;
                    if (r_nfc < NB'(TS)) begin
                        tab_we = 1'b1;
                        n_nfc = r_nfc + NB'(1);
                        if (n_nfc >= r_wl && r_wl < NB'(TS)) begin
                            n_wl = r_wl << 1;
                            n_cw = r_cw + 5'd1;
                        end
                    end
                    n_prev = r_incode;
                    do_emit = 1'b1;
                    pix = n_fs;
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                stk_we = 1'b1;
                stk_wdata = suf_rdata;
                n_depth = r_depth + NB'(1);
                n_code = pre_rdata;
                n_state = S_WALK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_emit) begin
            n_out_valid = 1'b1;
            n_out.status = STAT_PIXEL;
            n_out.pixel_index = pix;
            n_out.pixel_x = r_col;
            n_out.pixel_y = r_row;
            n_out.is_transparent = r_ten && (pix == r_tidx);
            n_out.last_pixel = (17'(r_row) + 17'd1 >= 17'(r_h))
                && (17'(r_col) + 17'd1 >= 17'(r_w));
            if (17'(r_col) + 17'd1 >= 17'(r_w)) begin
                n_col = '0;
                n_row = r_row + 16'd1;
            end else begin
                n_col = r_col + 16'd1;
            end
        end
        if (do_stat) begin
            n_out_valid = 1'b1;
            n_out = '0;
            n_out.status = stat;
        end

        if (cfg_fire) begin
            case (i_cfg_index)
                REG_MIN_CODE: begin
                    n_min = i_cfg_data[3:0];
                    ceff  = f_eff(i_cfg_data[3:0]);
                    n_cw  = 5'(ceff) + 5'd1;
                    n_nfc = (NB'(1) << ceff) + NB'(2);
                    n_wl  = NB'(1) << (ceff + 4'd1);
                end
                REG_WIDTH:     n_w = i_cfg_data;
                REG_HEIGHT:    n_h = i_cfg_data;
                REG_TRANS_EN:  n_ten = i_cfg_data[0];
                REG_TRANS_IDX: n_tidx = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min <= 4'd8;  r_w <= 16'd1;  r_h <= 16'd1;  r_ten <= 1'b0;  r_tidx <= 8'd0;
            r_depth <= '0;  r_buf <= '0;  r_cnt <= '0;  r_left <= '0;  r_ended <= 1'b0;
            r_cw <= 5'd9;  r_nfc <= NB'(258);  r_wl <= NB'(512);
            r_prev <= '0;  r_code <= '0;  r_incode <= '0;  r_fs <= '0;  r_ac <= 1'b0;
            r_col <= '0;  r_row <= '0;  r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_min <= n_min;  r_w <= n_w;  r_h <= n_h;  r_ten <= n_ten;  r_tidx <= n_tidx;
            r_depth <= n_depth;  r_buf <= n_buf;  r_cnt <= n_cnt;  r_left <= n_left;
            r_ended <= n_ended;  r_cw <= n_cw;  r_nfc <= n_nfc;  r_wl <= n_wl;
            r_prev <= n_prev;  r_code <= n_code;  r_incode <= n_incode;  r_fs <= n_fs;
            r_ac <= n_ac;  r_col <= n_col;  r_row <= n_row;  r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NB'(SS)) else $error("stack depth overflow");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready) else $error("word taken while busy");
    a_cw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cw <= 5'(CB)) else $error("code width too large");
    a_nfc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfc <= NB'(TS)) else $error("next free code past table");
endmodule
